FILE: sv/psw_pkg.sv
// Shared types for the priority schedule block: request, response and the
// packed process entry kept in the process memory. No dependencies.
`timescale 1ns / 1ps

package psw_pkg;

   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int NUM_W   = 5;
   localparam int TIME_W  = 20;

   typedef struct packed {
      logic [BURST_W-1:0] burst_time;
      logic [PRIO_W-1:0]  priority_level;
      logic               last_process;
   } psw_req_type;

   typedef struct packed {
      logic [NUM_W-1:0]   process_number;
      logic [BURST_W-1:0] burst_out;
      logic [TIME_W-1:0]  waiting_time;
      logic [TIME_W-1:0]  turnaround_time;
      logic [TIME_W-1:0]  average_waiting;
      logic [TIME_W-1:0]  average_turnaround;
      logic               overflow_flag;
      logic               last_result;
   } psw_rsp_type;

   // one stored process
   typedef struct packed {
      logic [PRIO_W-1:0]  priority_level;
      logic [BURST_W-1:0] burst;
      logic [NUM_W-1:0]   number;
   } psw_entry_type;

endpackage

FILE: sv/psw_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module psw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/psw_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module psw_div #(
   parameter int DIVIDEND_W = 26,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;

   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  ge;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge       = (rem_sh >= {1'b0, divisor});
      rem_diff = rem_sh - {1'b0, divisor};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // dividend shifts out the top while quotient bits enter the bottom
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         rem_in = ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/priority_schedule_waiting_times.sv
// Non-preemptive priority scheduler: loads processes, sorts them by priority
// in the process memory and reports waiting and turnaround times.
// Depends on psw_pkg, psw_ram and psw_div.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  psw_req_type
//   rsp       out        rsp_valid / rsp_stall  psw_rsp_type
//
// Loading accepts one request per cycle. After the last request the selection
// sort runs in the memory: each position is scanned through the registered
// read port, then the swap is written back in two states (ST_SWAP_MIN,
// ST_SWAP_SEL), the memory port being the limit. The averages come from the
// bit-serial dividers, then each result is read and then captured. Reset is
// synchronous and clears control state only; the memory needs no clearing
// pass. req_stall is high outside the load phase; a stalled result holds the
// output register, and the next set may load while the final result still
// waits.
`timescale 1ns / 1ps

module priority_schedule_waiting_times #(
   parameter int MAX_PROCS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  psw_pkg::psw_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output psw_pkg::psw_rsp_type  rsp_data
);

   import psw_pkg::*;

   localparam int CNT_W   = $clog2(MAX_PROCS + 1);
   localparam int ADDR_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int SUM_W   = BURST_W + CNT_W;
   localparam int TOT_W   = SUM_W + CNT_W;
   localparam int ENTRY_W = $bits(psw_entry_type);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SWAP_MIN,
      ST_SWAP_SEL,
      ST_DIV,
      ST_EMIT_RD,
      ST_EMIT_CAP
   } state_type;

   state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              dropped_ff, dropped_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              rvalid_ff, rvalid_in;
   logic [ADDR_W-1:0] ridx_ff, ridx_in;
   logic [ADDR_W-1:0] sel_ff, sel_in;
   psw_entry_type     cur_ff, cur_in;
   psw_entry_type     min_ff, min_in;
   logic [SUM_W-1:0]  prefix_ff, prefix_in;
   logic [TOT_W-1:0]  wtot_ff, wtot_in;
   logic [TOT_W-1:0]  ttot_ff, ttot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   psw_rsp_type       rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   psw_entry_type     wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   psw_entry_type     rd_data;

   logic              div_start;
   logic              done_w, done_t;
   logic [TOT_W-1:0]  quo_w, quo_t;

   logic              req_fire;
   logic [CNT_W:0]    num_full;
   logic [SUM_W-1:0]  prefix_next;
   logic              fin;

   psw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PROCS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data = psw_entry_type'(rd_raw);

   psw_div #(
      .DIVIDEND_W (TOT_W),
      .DIVISOR_W  (CNT_W)
   ) u_div_wait (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wtot_ff),
      .divisor  (cnt_ff),
      .done     (done_w),
      .quotient (quo_w)
   );

   psw_div #(
      .DIVIDEND_W (TOT_W),
      .DIVISOR_W  (CNT_W)
   ) u_div_turn (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ttot_ff),
      .divisor  (cnt_ff),
      .done     (done_t),
      .quotient (quo_t)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dropped_in   = dropped_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rvalid_in    = 1'b0;
      ridx_in      = j_ff[ADDR_W-1:0];
      sel_in       = sel_ff;
      cur_in       = cur_ff;
      min_in       = min_ff;
      prefix_in    = prefix_ff;
      wtot_in      = wtot_ff;
      ttot_in      = ttot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      num_full    = {1'b0, cnt_ff} + 1'b1;
      prefix_next = '0;
      fin         = 1'b0;

      wr_en   = 1'b0;
      wr_addr = cnt_ff[ADDR_W-1:0];
      wr_data.priority_level = req_data.priority_level;
      wr_data.burst          = req_data.burst_time;
      wr_data.number         = NUM_W'(num_full);
      rd_addr   = j_ff[ADDR_W-1:0];
      div_start = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (cnt_ff < CNT_W'(MAX_PROCS)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_process) begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (j_ff < cnt_ff) begin
               rvalid_in = 1'b1;
               j_in      = j_ff + 1'b1;
            end
            if (rvalid_ff) begin
               // first read of the pass is the entry at position i
               if (ridx_ff == i_ff[ADDR_W-1:0]) begin
                  cur_in = rd_data;
                  min_in = rd_data;
                  sel_in = ridx_ff;
               end else if (rd_data.priority_level < min_ff.priority_level) begin
                  min_in = rd_data;
                  sel_in = ridx_ff;
               end
               if (CNT_W'(ridx_ff) + 1'b1 == cnt_ff) begin
                  state_in = ST_SWAP_MIN;
               end
            end
         end

         ST_SWAP_MIN: begin
            wr_en       = 1'b1;
            wr_addr     = i_ff[ADDR_W-1:0];
            wr_data     = min_ff;
            prefix_next = prefix_ff + SUM_W'(min_ff.burst);
            wtot_in     = wtot_ff + TOT_W'(prefix_ff);
            ttot_in     = ttot_ff + TOT_W'(prefix_next);
            prefix_in   = prefix_next;
            state_in    = ST_SWAP_SEL;
         end

         ST_SWAP_SEL: begin
            wr_en   = 1'b1;
            wr_addr = sel_ff;
            wr_data = cur_ff;
            i_in    = i_ff + 1'b1;
            j_in    = i_ff + 1'b1;
            if (i_ff + 1'b1 == cnt_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_DIV: begin
            if (done_w) begin
               prefix_in = '0;
               k_in      = '0;
               state_in  = ST_EMIT_RD;
            end
         end

         ST_EMIT_RD: begin
            rd_addr = k_ff[ADDR_W-1:0];
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_EMIT_CAP;
            end
         end

         ST_EMIT_CAP: begin
            rd_addr     = k_ff[ADDR_W-1:0];
            fin         = (k_ff + 1'b1 == cnt_ff);
            prefix_next = prefix_ff + SUM_W'(rd_data.burst);

            rsp_valid_in                   = 1'b1;
            rsp_data_in.process_number     = rd_data.number;
            rsp_data_in.burst_out          = rd_data.burst;
            rsp_data_in.waiting_time       = TIME_W'(prefix_ff);
            rsp_data_in.turnaround_time    = TIME_W'(prefix_next);
            rsp_data_in.average_waiting    = fin ? TIME_W'(quo_w) : '0;
            rsp_data_in.average_turnaround = fin ? TIME_W'(quo_t) : '0;
            rsp_data_in.overflow_flag      = dropped_ff;
            rsp_data_in.last_result        = fin;

            prefix_in = prefix_next;
            k_in      = k_ff + 1'b1;
            if (fin) begin
               cnt_in     = '0;
               dropped_in = 1'b0;
               prefix_in  = '0;
               wtot_in    = '0;
               ttot_in    = '0;
               state_in   = ST_LOAD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         dropped_ff   <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rvalid_ff    <= 1'b0;
         prefix_ff    <= '0;
         wtot_ff      <= '0;
         ttot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dropped_ff   <= dropped_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rvalid_ff    <= rvalid_in;
         prefix_ff    <= prefix_in;
         wtot_ff      <= wtot_in;
         ttot_ff      <= ttot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ridx_ff     <= ridx_in;
      sel_ff      <= sel_in;
      cur_ff      <= cur_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_PROCS))
      else $error("loaded count beyond capacity");

   a_cap_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_CAP) |-> !rsp_valid_ff)
      else $error("result captured over a pending one");

   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWAP_MIN) |-> (CNT_W'(sel_ff) >= i_ff && CNT_W'(sel_ff) < cnt_ff))
      else $error("selected entry outside the unsorted range");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_w == done_t)
      else $error("dividers out of step");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_CAP && k_ff + 1'b1 == cnt_ff) |=>
         (state_ff == ST_LOAD && cnt_ff == '0 && !dropped_ff))
      else $error("set not cleared after final result");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for priority_schedule_waiting_times: directed table,
// then random process sets under several idle and stall patterns.
// Depends on psw_pkg and the priority_schedule_waiting_times RTL.
`timescale 1ns / 1ps

module testbench;
   import psw_pkg::*;

   localparam int PROC_SLOTS     = 16;
   localparam int HOLDOFF_CYCLES = 500;
   localparam int SETTLE_CYCLES  = 300;
   localparam int PHASE_COUNT    = 4;
   localparam int PHASE_ITEMS    = 85;

   typedef struct {
      psw_req_type req;
      bit          typed;
      psw_rsp_type result;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   psw_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   psw_rsp_type rsp_data;

   // shadow of the process memory and set bookkeeping
   bit [BURST_W-1:0] held_burst[PROC_SLOTS];
   bit [PRIO_W-1:0]  held_prio[PROC_SLOTS];
   bit [NUM_W-1:0]   held_number[PROC_SLOTS];
   int unsigned      held_count = 0;
   bit               held_dropped = 1'b0;
   psw_rsp_type      planned[PROC_SLOTS];

   psw_rsp_type  due_results[$];
   plan_row_type directed_rows[$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           holdoff_asked = 0;
   int           holdoff_served = 0;
   int           holdoff_left = 0;

   priority_schedule_waiting_times #(.MAX_PROCS(PROC_SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Loads one process; on the last one sorts the set and fills planned[].
   // Returns the number of results the set produces.
   function automatic int schedule_step(psw_req_type r);
      int               n;
      int               sel;
      bit [BURST_W-1:0] b;
      bit [PRIO_W-1:0]  p;
      bit [NUM_W-1:0]   num;
      longint unsigned  prefix;
      longint unsigned  wsum;
      longint unsigned  tsum;
      bit               fin;
      if (held_count < PROC_SLOTS) begin
         held_burst[held_count]  = r.burst_time;
         held_prio[held_count]   = r.priority_level;
         held_number[held_count] = NUM_W'(held_count + 1);
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (!r.last_process) return 0;
      n = held_count;
      // selection sort, first strictly smallest wins so ties may reorder
      for (int i = 0; i < n; i++) begin
         sel = i;
         for (int j = i + 1; j < n; j++)
            if (held_prio[j] < held_prio[sel]) sel = j;
         b = held_burst[i];   held_burst[i]  = held_burst[sel];  held_burst[sel]  = b;
         p = held_prio[i];    held_prio[i]   = held_prio[sel];   held_prio[sel]   = p;
         num = held_number[i]; held_number[i] = held_number[sel]; held_number[sel] = num;
      end
      prefix = 0;
      wsum = 0;
      tsum = 0;
      for (int i = 0; i < n; i++) begin
         wsum += prefix;
         tsum += prefix + held_burst[i];
         prefix += held_burst[i];
      end
      prefix = 0;
      for (int i = 0; i < n; i++) begin
         fin = (i == n - 1);
         planned[i].process_number     = held_number[i];
         planned[i].burst_out          = held_burst[i];
         planned[i].waiting_time       = TIME_W'(prefix);
         planned[i].turnaround_time    = TIME_W'(prefix + held_burst[i]);
         planned[i].average_waiting    = fin ? TIME_W'(wsum / n) : '0;
         planned[i].average_turnaround = fin ? TIME_W'(tsum / n) : '0;
         planned[i].overflow_flag      = held_dropped;
         planned[i].last_result        = fin;
         prefix += held_burst[i];
      end
      held_count = 0;
      held_dropped = 1'b0;
      return n;
   endfunction

   function automatic plan_row_type load_row(int burst, int prio, bit last);
      plan_row_type row;
      row.req.burst_time     = BURST_W'(burst);
      row.req.priority_level = PRIO_W'(prio);
      row.req.last_process   = last;
      row.typed  = 1'b0;
      row.result = '0;
      return row;
   endfunction

   task automatic offer(input psw_req_type r, input bit typed, input psw_rsp_type typed_result);
      int n;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      n = schedule_step(r);
      items_sent++;
      if (typed) due_results.push_back(typed_result);
      else for (int i = 0; i < n; i++) due_results.push_back(planned[i]);
   endtask

   task automatic sender_gap();
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_random_set();
      int          n;
      int          pick;
      bit          tie_heavy;
      psw_req_type r;
      pick = $urandom_range(99);
      if (pick < 75)      n = $urandom_range(8, 1);
      else if (pick < 95) n = $urandom_range(PROC_SLOTS, 9);
      else                n = $urandom_range(PROC_SLOTS + 4, PROC_SLOTS + 1);
      tie_heavy = ($urandom_range(2) == 0);
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(9);
         if (pick < 6)      r.burst_time = BURST_W'($urandom);
         else if (pick < 9) r.burst_time = BURST_W'($urandom_range(15));
         else               r.burst_time = '1;
         r.priority_level = tie_heavy ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
         r.last_process   = (k == n - 1);
         sender_gap();
         offer(r, 1'b0, '0);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result(psw_rsp_type got);
      psw_rsp_type want;
      if (due_results.size() == 0) begin
         $error("unexpected result: process_number %0d", got.process_number);
         mismatches++;
         return;
      end
      want = due_results.pop_front();
      compare_field("process_number", 32'(want.process_number), 32'(got.process_number));
      compare_field("burst_out", 32'(want.burst_out), 32'(got.burst_out));
      compare_field("waiting_time", 32'(want.waiting_time), 32'(got.waiting_time));
      compare_field("turnaround_time", 32'(want.turnaround_time),
                    32'(got.turnaround_time));
      compare_field("average_waiting", 32'(want.average_waiting),
                    32'(got.average_waiting));
      compare_field("average_turnaround", 32'(want.average_turnaround),
                    32'(got.average_turnaround));
      compare_field("overflow_flag", 32'(want.overflow_flag), 32'(got.overflow_flag));
      compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
   endtask

   // result side: check, then pick the stall for the next cycle
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_result(rsp_data);
         if (holdoff_left == 0 && holdoff_served != holdoff_asked) begin
            holdoff_served++;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      plan_row_type row;
      int           idle_of_phase[PHASE_COUNT];
      int           stall_of_phase[PHASE_COUNT];

      idle_of_phase  = '{0, 61, 0, 23};
      stall_of_phase = '{0, 0, 61, 23};

      // single-process sets at both extremes, result known outright
      row = load_row(0, 0, 1'b1);
      row.typed = 1'b1;
      row.result = '{process_number: 1, burst_out: 0, waiting_time: 0, turnaround_time: 0,
                     average_waiting: 0, average_turnaround: 0, overflow_flag: 0,
                     last_result: 1};
      directed_rows.push_back(row);
      row = load_row(65535, 255, 1'b1);
      row.typed = 1'b1;
      row.result = '{process_number: 1, burst_out: 65535, waiting_time: 0,
                     turnaround_time: 65535, average_waiting: 0,
                     average_turnaround: 65535, overflow_flag: 0, last_result: 1};
      directed_rows.push_back(row);
      // equal priorities that the sort swaps out of arrival order
      directed_rows.push_back(load_row(5, 2, 1'b0));
      directed_rows.push_back(load_row(7, 2, 1'b0));
      directed_rows.push_back(load_row(9, 1, 1'b1));
      // full set of maximum bursts, then a last request that gets dropped
      for (int i = 0; i < PROC_SLOTS; i++)
         directed_rows.push_back(load_row(65535, ((PROC_SLOTS - 1 - i) / 4) * 85, 1'b0));
      directed_rows.push_back(load_row(0, 0, 1'b1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         send_idle_pct  = idle_of_phase[p];
         recv_stall_pct = stall_of_phase[p];
         // long receiver hold-off while requests keep coming
         if (p == 0) holdoff_asked++;
         while (items_sent < directed_rows.size() + PHASE_ITEMS * (p + 1))
            send_random_set();
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
